// ===== rtl/core/trcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trcb_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned BurstW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW   = CountW + PctW;

  // Item kinds
  localparam logic ModeCompletion = 1'b0;
  localparam logic ModeProbe      = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgWindowIdx  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBurstIdx   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinToIdx   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRatioIdx   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRetryIdx   = 3'd4;

  // Register reset values
  localparam logic [CfgW-1:0] WindowReset = 16'd60;
  localparam logic [CfgW-1:0] BurstReset  = 16'd5;
  localparam logic [CfgW-1:0] MinToReset  = 16'd2;
  localparam logic [PctW-1:0] RatioReset  = 7'd50;
  localparam logic [CfgW-1:0] RetryReset  = 16'd30;

  // Early close needs more than this many seconds in the window
  localparam logic [TimeW-1:0] EarlyCloseMin = 32'd10;
  // Scale of a percentage
  localparam logic [PctW-1:0]  PercentScale  = 7'd100;

  typedef struct packed {
    logic [CfgW-1:0] window_seconds;
    logic [CfgW-1:0] burst_fail_limit;
    logic [CfgW-1:0] min_timeouts;
    logic [PctW-1:0] ratio_percent;
    logic [CfgW-1:0] retry_seconds;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic             timed_out;
    logic [TimeW-1:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic enabled;
    logic probe_allowed;
    logic just_disabled;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/trcb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface trcb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic                       timed_out;
  logic [trcb_pkg::TimeW-1:0] now_seconds;

  modport source (output valid, output mode, output timed_out, output now_seconds,
                  input ready);
  modport sink   (input valid, input mode, input timed_out, input now_seconds,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trcb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface trcb_out_if;
  logic valid;
  logic ready;
  logic enabled;
  logic probe_allowed;
  logic just_disabled;

  modport source (output valid, output enabled, output probe_allowed,
                  output just_disabled, input ready);
  modport sink   (input valid, input enabled, input probe_allowed,
                  input just_disabled, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trcb_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface trcb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [trcb_pkg::CfgIdxW-1:0] index;
  logic [trcb_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trcb_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trcb_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  trcb_cfg_if.sink            cfg_i,
  output trcb_pkg::cfg_t      cfg_o
);
  import trcb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always take a write beat
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgWindowIdx: cfg_d.window_seconds   = cfg_i.data;
        CfgBurstIdx:  cfg_d.burst_fail_limit = cfg_i.data;
        CfgMinToIdx:  cfg_d.min_timeouts     = cfg_i.data;
        CfgRatioIdx:  cfg_d.ratio_percent    = cfg_i.data[PctW-1:0];
        CfgRetryIdx:  cfg_d.retry_seconds    = cfg_i.data;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_seconds   <= WindowReset;
      cfg_q.burst_fail_limit <= BurstReset;
      cfg_q.min_timeouts     <= MinToReset;
      cfg_q.ratio_percent    <= RatioReset;
      cfg_q.retry_seconds    <= RetryReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/trcb_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trcb_update (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire trcb_pkg::item_t item_i,
  input  wire trcb_pkg::cfg_t  cfg_i,
  output trcb_pkg::result_t   result_o
);
  import trcb_pkg::*;

  logic              active_q, active_d;
  logic [BurstW-1:0] burst_q, burst_d;
  logic [CountW-1:0] calls_q, calls_d;
  logic [CountW-1:0] touts_q, touts_d;
  logic [TimeW-1:0]  win_start_q, win_start_d;
  logic [TimeW-1:0]  last_probe_q, last_probe_d;

  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  probe_gap;
  logic              probe_refused;
  logic [BurstW-1:0] burst_inc;
  logic [CountW-1:0] calls_inc;
  logic [CountW-1:0] touts_inc;
  logic              win_close;
  logic [ProdW-1:0]  tout_share;
  logic [ProdW-1:0]  ratio_need;
  logic              trip;

  // Elapsed times modulo the time width
  assign elapsed   = item_i.now_seconds - win_start_q;
  assign probe_gap = item_i.now_seconds - last_probe_q;
  assign probe_refused = !active_q &&
                         (probe_gap < {{(TimeW-CfgW){1'b0}}, cfg_i.retry_seconds});

  // Saturating counts for an enabled completion
  assign burst_inc = !item_i.timed_out ? '0 :
                     (&burst_q) ? burst_q : burst_q + 1'b1;
  assign calls_inc = (&calls_q) ? calls_q : calls_q + 1'b1;
  assign touts_inc = !item_i.timed_out ? touts_q :
                     (&touts_q) ? touts_q : touts_q + 1'b1;

  // Window close and trip test, exact without division
  assign win_close = (elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.window_seconds}) ||
                     ((burst_inc >= cfg_i.burst_fail_limit) && (elapsed > EarlyCloseMin));
  assign tout_share = {{PctW{1'b0}}, touts_inc} * {{CountW{1'b0}}, PercentScale};
  assign ratio_need = {{CountW{1'b0}}, cfg_i.ratio_percent} * {{PctW{1'b0}}, calls_inc};
  assign trip = win_close &&
                (touts_inc >= {{(CountW-CfgW){1'b0}}, cfg_i.min_timeouts}) &&
                (tout_share >= ratio_need);

  // Next state and result for the item in the input register
  always_comb begin
    active_d     = active_q;
    burst_d      = burst_q;
    calls_d      = calls_q;
    touts_d      = touts_q;
    win_start_d  = win_start_q;
    last_probe_d = last_probe_q;
    result_o     = '0;
    if (item_i.mode == ModeProbe) begin
      if (!probe_refused) begin
        last_probe_d           = item_i.now_seconds;
        result_o.probe_allowed = 1'b1;
      end
    end else if (!active_q) begin
      // A success re-enables; a timeout is dropped
      if (!item_i.timed_out) begin
        active_d    = 1'b1;
        win_start_d = item_i.now_seconds;
        burst_d     = '0;
        calls_d     = {{(CountW-1){1'b0}}, 1'b1};
        touts_d     = '0;
      end
    end else begin
      burst_d = burst_inc;
      calls_d = calls_inc;
      touts_d = touts_inc;
      if (win_close) begin
        win_start_d = item_i.now_seconds;
        burst_d     = '0;
        calls_d     = '0;
        touts_d     = '0;
        if (trip) begin
          active_d               = 1'b0;
          last_probe_d           = item_i.now_seconds;
          result_o.just_disabled = 1'b1;
        end
      end
    end
    result_o.enabled = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b1;
      burst_q      <= '0;
      calls_q      <= '0;
      touts_q      <= '0;
      win_start_q  <= '0;
      last_probe_q <= '0;
    end else if (step_i) begin
      active_q     <= active_d;
      burst_q      <= burst_d;
      calls_q      <= calls_d;
      touts_q      <= touts_d;
      win_start_q  <= win_start_d;
      last_probe_q <= last_probe_d;
    end
  end

  // Counts stay clear while the endpoint is off
  a_clear_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (burst_q == '0) && (calls_q == '0) && (touts_q == '0))
    else $error("counts not clear while disabled");

  // A disable beat leaves the endpoint off
  a_disable_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.just_disabled |=> !active_q)
    else $error("endpoint still active after a disable");

  // Only a probe can be allowed
  a_probe_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.probe_allowed |-> (item_i.mode == ModeProbe) && !result_o.just_disabled)
    else $error("probe_allowed on a completion");

  // A stamped probe moves last_probe to now
  a_probe_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.probe_allowed |=> last_probe_q == $past(item_i.now_seconds))
    else $error("allowed probe not stamped");

endmodule

`default_nettype wire

// ===== rtl/core/timeout_ratio_circuit_breaker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Endpoint health breaker with a timeout-ratio trip. Each input beat is a
// request completion (with a timed-out flag) or a probe check, stamped with
// the time in seconds; each gives exactly one result beat carrying enabled,
// probe_allowed and just_disabled. The block takes one beat per clock cycle
// while the result channel is not stalled, and each result is registered:
// while the beat sits in the input register, the update stage reads it with
// the breaker state, and the edge on which it advances writes the state and
// loads the result register. Back-pressure on the result channel stalls both
// registers together. Configuration writes are taken in any cycle and should
// only be issued while no beat is in flight.
module timeout_ratio_circuit_breaker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  trcb_cfg_if.sink    cfg_i,
  trcb_in_if.sink     item_i,
  trcb_out_if.source  result_o
);
  import trcb_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t step_result;
  result_t result_q;
  logic    result_valid_q;
  logic    out_free;
  logic    step;

  // Advance the pipe whenever the result register is free or being drained
  assign out_free     = !result_valid_q || result_o.ready;
  assign step         = item_valid_q && out_free;
  assign item_i.ready = !item_valid_q || out_free;

  trcb_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  trcb_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        item_valid_q <= item_i.valid;
      end
      if (out_free) begin
        result_valid_q <= item_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.mode        <= item_i.mode;
      item_q.timed_out   <= item_i.timed_out;
      item_q.now_seconds <= item_i.now_seconds;
    end
    if (step) begin
      result_q <= step_result;
    end
  end

  assign result_o.valid         = result_valid_q;
  assign result_o.enabled       = result_q.enabled;
  assign result_o.probe_allowed = result_q.probe_allowed;
  assign result_o.just_disabled = result_q.just_disabled;

endmodule

`default_nettype wire
